FILE: hdl/dma_pkg.sv
// ----------------------------------------------------------------------------
// dma_pkg
// Shared sizes and types of the dual moving average: window lengths, sum and
// count widths, divider step sizing and the entry format of the work queue.
// ----------------------------------------------------------------------------
package dma_pkg;

	localparam int SHORT_WINDOW = 5;
	localparam int LONG_WINDOW  = 10;
	localparam int SAMPLE_BITS  = 32;

	localparam int VOLUME_BITS  = 32;
	localparam int AVG_BITS     = 40;
	localparam int FRAC_BITS    = 8;

	localparam int IN_DATA_BITS  = ((VOLUME_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 * AVG_BITS + 7) / 8) * 8;

	localparam int HIST_DEPTH = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
	localparam int CNT_BITS   = $clog2(HIST_DEPTH + 1);

	localparam int SHORT_SUM_BITS = SAMPLE_BITS + $clog2(SHORT_WINDOW);
	localparam int LONG_SUM_BITS  = SAMPLE_BITS + $clog2(LONG_WINDOW);
	localparam int MAX_SUM_BITS   = (SHORT_SUM_BITS > LONG_SUM_BITS) ?
		SHORT_SUM_BITS : LONG_SUM_BITS;

	localparam int STEP_BITS     = 8;
	localparam int DIV_W         = ((MAX_SUM_BITS + FRAC_BITS + STEP_BITS - 1) / STEP_BITS)
		* STEP_BITS;
	localparam int DIV_STEPS     = DIV_W / STEP_BITS;
	localparam int STEP_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic [SHORT_SUM_BITS-1:0] short_sum;
		logic [LONG_SUM_BITS-1:0]  long_sum;
		logic [CNT_BITS-1:0]       n_short;
		logic [CNT_BITS-1:0]       n_long;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: hdl/dual_moving_average.sv
// ----------------------------------------------------------------------------
// dual_moving_average
// Short and long window simple moving averages of a volume stream, unsigned
// fixed point with 8 fraction bits, truncated.
//
//   channel   dir  tdata                            tuser
//   s_axis    in   volume[31:0]                     start_of_series
//   m_axis    out  avg_short[39:0], avg_long[79:40]  -
//
// the front end takes one item per cycle while the two-entry queue has room
// each result takes the divider from IDLE through RUN to DONE, and a new item
// is popped only in IDLE, after the last result has moved to the output register
// reset clears the delay line, sums, sample count, queue and output valid flag
// a stalled output holds the divider in its done state; the queue then fills
// and s_axis_tready drops
// ----------------------------------------------------------------------------
module dual_moving_average (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [dma_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // volume
	input  logic                               s_axis_tuser,  // start_of_series
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [dma_pkg::OUT_DATA_BITS-1:0] m_axis_tdata   // avg_short, avg_long
);
	import dma_pkg::*;

	q_status_t q_status;
	q_entry_t  push_entry, pop_entry;
	logic      push, pop;

	dma_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.volume          (s_axis_tdata[VOLUME_BITS-1:0]),
		.start_of_series (s_axis_tuser),
		.q_status        (q_status),
		.push            (push),
		.push_entry      (push_entry)
	);

	dma_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	dma_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_entry (pop_entry),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry.n_short != '0) && (push_entry.n_long != '0))
		else $error("zero divisor pushed");

	a_divisor_capped: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry.n_short <= CNT_BITS'(SHORT_WINDOW))
			&& (push_entry.n_long <= CNT_BITS'(LONG_WINDOW)))
		else $error("divisor above window length");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue full and empty at once");

	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !pop)
		else $error("divider popped while busy");

endmodule

FILE: hdl/dma_front.sv
// ----------------------------------------------------------------------------
// dma_front
// Accepts samples, keeps the delay line, running sums and sample count, and
// pushes the updated sums with their divisors into the work queue.
// ----------------------------------------------------------------------------
module dma_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dma_pkg::VOLUME_BITS-1:0] volume,
	input  logic                          start_of_series,
	input  dma_pkg::q_status_t            q_status,
	output logic                          push,
	output dma_pkg::q_entry_t             push_entry
);
	import dma_pkg::*;

	sample_t                   hist_q [HIST_DEPTH];
	logic [SHORT_SUM_BITS-1:0] short_sum_q;
	logic [LONG_SUM_BITS-1:0]  long_sum_q;
	logic [CNT_BITS-1:0]       seen_q;

	sample_t                   sample;
	sample_t                   hist_eff [HIST_DEPTH];
	logic [SHORT_SUM_BITS-1:0] short_base, short_drop, short_next;
	logic [LONG_SUM_BITS-1:0]  long_base, long_drop, long_next;
	logic [CNT_BITS-1:0]       seen_eff, seen_next;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;
	assign sample   = SAMPLE_BITS'(volume);

	always_comb begin
		for (int i = 0; i < HIST_DEPTH; i++) begin
			hist_eff[i] = start_of_series ? '0 : hist_q[i];
		end
		seen_eff   = start_of_series ? '0 : seen_q;
		short_base = start_of_series ? '0 : short_sum_q;
		long_base  = start_of_series ? '0 : long_sum_q;
		short_drop = (seen_eff >= CNT_BITS'(SHORT_WINDOW)) ?
			SHORT_SUM_BITS'(hist_eff[SHORT_WINDOW-1]) : '0;
		long_drop  = (seen_eff >= CNT_BITS'(LONG_WINDOW)) ?
			LONG_SUM_BITS'(hist_eff[LONG_WINDOW-1]) : '0;
		short_next = short_base - short_drop + SHORT_SUM_BITS'(sample);
		long_next  = long_base - long_drop + LONG_SUM_BITS'(sample);
		seen_next  = (seen_eff < CNT_BITS'(HIST_DEPTH)) ? seen_eff + 1'b1 : seen_eff;

		push_entry.short_sum = short_next;
		push_entry.long_sum  = long_next;
		push_entry.n_short   = (seen_next < CNT_BITS'(SHORT_WINDOW)) ?
			seen_next : CNT_BITS'(SHORT_WINDOW);
		push_entry.n_long    = (seen_next < CNT_BITS'(LONG_WINDOW)) ?
			seen_next : CNT_BITS'(LONG_WINDOW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			short_sum_q <= '0;
			long_sum_q  <= '0;
			seen_q      <= '0;
		end else if (push) begin
			hist_q[0] <= sample;
			for (int i = 1; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_eff[i-1];
			end
			short_sum_q <= short_next;
			long_sum_q  <= long_next;
			seen_q      <= seen_next;
		end
	end

endmodule

FILE: hdl/dma_queue.sv
// ----------------------------------------------------------------------------
// dma_queue
// Short first-in first-out queue of sums and divisors between the front end
// and the divider.
// ----------------------------------------------------------------------------
module dma_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dma_pkg::q_entry_t push_entry,
	input  logic              pop,
	output dma_pkg::q_entry_t pop_entry,
	output dma_pkg::q_status_t status
);
	import dma_pkg::*;

	q_entry_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/dma_divider.sv
// ----------------------------------------------------------------------------
// dma_divider
// Two radix-256 restoring dividers that work in step: each takes the scaled
// sum of one window and divides it by that window's sample count, then the
// averages wait in the output register.
// ----------------------------------------------------------------------------
module dma_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dma_pkg::q_status_t                 q_status,
	input  dma_pkg::q_entry_t                  pop_entry,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dma_pkg::OUT_DATA_BITS-1:0] out_data
);
	import dma_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DONE
	} state_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] rem;
		logic [DIV_W-1:0]    work;
	} div_t;

	state_t                   state_q;
	logic [STEP_CNT_BITS-1:0] step_q;
	div_t                     short_q, long_q;
	logic [CNT_BITS-1:0]      d_short_q, d_long_q;
	logic                     out_valid_q;
	logic [AVG_BITS-1:0]      avg_short_q, avg_long_q;

	div_t short_step, long_step;
	logic load_out;

	function automatic div_t div_step(input div_t cur, input logic [CNT_BITS-1:0] d);
		div_t              r;
		logic [CNT_BITS:0] t;
		r = cur;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r.rem, r.work[DIV_W-1]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				r.work = {r.work[DIV_W-2:0], 1'b1};
			end else begin
				r.work = {r.work[DIV_W-2:0], 1'b0};
			end
			r.rem = t[CNT_BITS-1:0];
		end
		return r;
	endfunction

	assign short_step = div_step(short_q, d_short_q);
	assign long_step  = div_step(long_q, d_long_q);
	assign pop        = (state_q == IDLE) && !q_status.empty;
	assign load_out   = (state_q == DONE) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_data   = OUT_DATA_BITS'({avg_long_q, avg_short_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				avg_short_q <= AVG_BITS'(short_q.work);
				avg_long_q  <= AVG_BITS'(long_q.work);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (pop) begin
						short_q.rem  <= '0;
						short_q.work <= DIV_W'({pop_entry.short_sum, FRAC_BITS'(0)});
						long_q.rem   <= '0;
						long_q.work  <= DIV_W'({pop_entry.long_sum, FRAC_BITS'(0)});
						d_short_q    <= pop_entry.n_short;
						d_long_q     <= pop_entry.n_long;
						step_q       <= '0;
						state_q      <= RUN;
					end
				end
				RUN: begin
					short_q <= short_step;
					long_q  <= long_step;
					step_q  <= step_q + 1'b1;
					if (step_q == STEP_CNT_BITS'(DIV_STEPS - 1)) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (load_out) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

FILE: dv/dual_moving_average_tb.sv
// ----------------------------------------------------------------------------
// dual_moving_average_tb
// Self-checking bench for the short and long window moving averages. A
// directed run covers warm-up, saturation of the sample count, full-scale and
// zero samples and restarts; random series of mixed lengths and magnitudes
// follow. Each accepted item is run through a local fixed-point predictor and
// every output item is compared field by field with the oldest prediction,
// under random idle cycles on both sides outside one quiet window.
// ----------------------------------------------------------------------------
module dual_moving_average_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import dma_pkg::*;

	typedef struct {
		logic [VOLUME_BITS-1:0] volume;
		logic                   start;
		logic                   drain;
	} vol_item_t;

	typedef struct {
		logic [AVG_BITS-1:0] avg_short;
		logic [AVG_BITS-1:0] avg_long;
	} avg_pair_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;  // volume
	logic                     s_axis_tuser  = 1'b0;  // start_of_series
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;  // avg_short, avg_long

	vol_item_t   vol_items[$];
	avg_pair_t   pending_avgs[$];
	int unsigned n_taken   = 0;
	int unsigned n_checked = 0;
	int unsigned fails     = 0;
	int unsigned cyc       = 0;
	logic        quiet;

	logic [63:0] recent_vol [HIST_DEPTH];
	logic [63:0] short_total = '0;
	logic [63:0] long_total  = '0;
	int unsigned fill_count  = 0;

	dual_moving_average dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// no idling on either side in this window
	assign quiet = (cyc >= 4000) && (cyc < 6000);

	function automatic logic [AVG_BITS-1:0] scaled_mean(logic [63:0] total, int unsigned window);
		int unsigned n;
		logic [63:0] q;
		n = (fill_count < window) ? fill_count : window;
		if (n == 0)
			return '0;
		q = (total << FRAC_BITS) / 64'(n);
		return q[AVG_BITS-1:0];
	endfunction

	function automatic avg_pair_t advance_averages(logic [VOLUME_BITS-1:0] volume, logic start);
		logic [63:0] v;
		avg_pair_t r;
		v = 64'(volume) & ((64'd1 << SAMPLE_BITS) - 64'd1);
		if (start) begin
			for (int i = 0; i < HIST_DEPTH; i++)
				recent_vol[i] = '0;
			short_total = '0;
			long_total  = '0;
			fill_count  = 0;
		end
		if (fill_count >= SHORT_WINDOW)
			short_total = short_total - recent_vol[SHORT_WINDOW-1];
		short_total = short_total + v;
		if (fill_count >= LONG_WINDOW)
			long_total = long_total - recent_vol[LONG_WINDOW-1];
		long_total = long_total + v;
		for (int i = HIST_DEPTH - 1; i > 0; i--)
			recent_vol[i] = recent_vol[i-1];
		recent_vol[0] = v;
		if (fill_count < HIST_DEPTH)
			fill_count++;
		r.avg_short = scaled_mean(short_total, SHORT_WINDOW);
		r.avg_long  = scaled_mean(long_total, LONG_WINDOW);
		return r;
	endfunction

	task automatic add_item(logic [VOLUME_BITS-1:0] volume, logic start, logic drain = 1'b0);
		vol_item_t it;
		it.volume = volume;
		it.start  = start;
		it.drain  = drain;
		vol_items.push_back(it);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive
		logic take;
		logic hold;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			take = s_axis_tvalid && s_axis_tready;
			if (take)
				void'(vol_items.pop_front());
			hold = 1'b0;
			if (vol_items.size() != 0)
				hold = vol_items[0].drain && (n_taken + take != n_checked);
			if (s_axis_tvalid && !take) begin
				s_axis_tvalid <= 1'b1;
			end else if (vol_items.size() != 0 && !hold && (quiet || $urandom_range(99) >= 8)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= vol_items[0].volume;
				s_axis_tuser  <= vol_items[0].start;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin : observe
		avg_pair_t want;
		logic [AVG_BITS-1:0] got_short;
		logic [AVG_BITS-1:0] got_long;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_avgs.push_back(advance_averages(s_axis_tdata[VOLUME_BITS-1:0],
					s_axis_tuser));
				n_taken <= n_taken + 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_checked <= n_checked + 1;
				got_short = m_axis_tdata[AVG_BITS-1:0];
				got_long  = m_axis_tdata[2*AVG_BITS-1:AVG_BITS];
				if (pending_avgs.size() == 0) begin
					$display("%0t: unexpected item, avg_short %h avg_long %h",
						$realtime, got_short, got_long);
					fails++;
				end else begin
					want = pending_avgs.pop_front();
					if (got_short !== want.avg_short) begin
						$display("%0t: avg_short expected %h actual %h",
							$realtime, want.avg_short, got_short);
						fails++;
					end
					if (got_long !== want.avg_long) begin
						$display("%0t: avg_long expected %h actual %h",
							$realtime, want.avg_long, got_long);
						fails++;
					end
				end
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 8);
		end
	end

	initial begin : stimulus
		int unsigned total;
		int unsigned len;
		int unsigned pick;
		logic [VOLUME_BITS-1:0] vol;
		logic start;

		// first sample after reset, no start flag
		add_item(32'd100, 1'b0);
		// full scale past the long window, count saturates
		for (int i = 0; i < 11; i++)
			add_item('1, 1'b0);
		add_item('0, 1'b1);
		add_item('1, 1'b1);
		add_item(32'd1, 1'b0);
		add_item(32'h8000_0000, 1'b0);
		// wait for everything before restarting
		add_item(32'd7, 1'b1, 1'b1);
		add_item(32'hAAAA_AAAA, 1'b0);
		add_item(32'h5555_5555, 1'b0);
		add_item(32'hFFFF_0000, 1'b0);
		add_item(32'h0000_FFFF, 1'b0);
		add_item(32'hF0F0_F0F0, 1'b0);
		add_item(32'h0F0F_0F0F, 1'b0);
		add_item('0, 1'b0);

		total = vol_items.size();
		while (total < 1350) begin
			pick = $urandom_range(99);
			len  = (pick < 10) ? $urandom_range(26, 40) : $urandom_range(1, 25);
			start = ($urandom_range(99) < 90);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(99);
				if (pick < 50)
					vol = $urandom;
				else if (pick < 70)
					vol = $urandom_range(1000);
				else if (pick < 80)
					vol = '1;
				else if (pick < 90)
					vol = 32'hFFFF_FF00 | $urandom_range(255);
				else
					vol = '0;
				if (i == 0)
					add_item(vol, start, $urandom_range(99) < 3);
				else
					add_item(vol, $urandom_range(99) < 2);
				total++;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (vol_items.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (n_checked < n_taken)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (pending_avgs.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $realtime, pending_avgs.size());
			fails++;
		end
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("%0t: timeout", $realtime);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hdl/dma_pkg.sv
hdl/dma_front.sv
hdl/dma_queue.sv
hdl/dma_divider.sv
hdl/dual_moving_average.sv
dv/dual_moving_average_tb.sv
